@@ hdl/assert_macros.svh @@
// assertion macros shared by the i2c master sequencer files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CHK_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define CHK_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/i2cm_pkg.sv @@
// shared types and constants of the i2c master sequencer
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int COUNT_BITS_DEF = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

    localparam logic [7:0] PHASE_TICKS_RST = 8'd6;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_PROBE = 2'd3;

    localparam logic [7:0] DEV_WR_MASK = 8'hFE;
    localparam logic [7:0] DEV_RD_BIT  = 8'h01;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [15:0] byte_count;
        logic [7:0]  write_byte;
        logic        sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       byte_taken;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done_res;
        logic       status;
    } i2cm_out_t;

    // effective settings seen by the sequencer
    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [7:0] ack_timeout;
    } i2cm_cfg_t;

    typedef enum logic [21:0] {
        PH_IDLE     = 22'h000001,
        PH_ST_SDA_H = 22'h000002,
        PH_ST_SCL_H = 22'h000004,
        PH_ST_SDA_L = 22'h000008,
        PH_ST_SCL_L = 22'h000010,
        PH_TX_DATA  = 22'h000020,
        PH_TX_SCL_H = 22'h000040,
        PH_TX_SCL_L = 22'h000080,
        PH_AK_SDA_H = 22'h000100,
        PH_AK_SCL_H = 22'h000200,
        PH_AK_WAIT  = 22'h000400,
        PH_AK_SCL_L = 22'h000800,
        PH_RX_SCL_H = 22'h001000,
        PH_RX_SCL_L = 22'h002000,
        PH_MA_SCL_L = 22'h004000,
        PH_MA_SDA   = 22'h008000,
        PH_MA_SCL_H = 22'h010000,
        PH_MA_SCL_L2 = 22'h020000,
        PH_SP_SCL_L = 22'h040000,
        PH_SP_SDA_L = 22'h080000,
        PH_SP_SCL_H = 22'h100000,
        PH_SP_SDA_H = 22'h200000
    } phase_t;

    typedef enum logic [4:0] {
        STG_ADDR_W = 5'b00001,
        STG_REG    = 5'b00010,
        STG_ADDR_R = 5'b00100,
        STG_DATA   = 5'b01000,
        STG_PROBE  = 5'b10000
    } stage_t;

endpackage

@@ hdl/i2cm_cfg.sv @@
// configuration registers of the i2c master sequencer
`timescale 1ns / 1ps

module i2cm_cfg
    import i2cm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output i2cm_cfg_t            cfg
);

    logic [7:0] phase_ticks_reg, phase_ticks_next;
    logic [7:0] ack_timeout_reg, ack_timeout_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        phase_ticks_next = phase_ticks_reg;
        ack_timeout_next = ack_timeout_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PHASE_TICKS: phase_ticks_next = cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end
        else
        begin
            phase_ticks_reg <= phase_ticks_next;
            ack_timeout_reg <= ack_timeout_next;
        end
    end

    // zero phase length runs as one tick
    assign cfg.phase_ticks = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign cfg.ack_timeout = ack_timeout_reg;

endmodule

@@ hdl/i2cm_seq.sv @@
// bus phase sequencer: state registers and one-tick update
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cm_seq
    import i2cm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  i2cm_in_t  item,
    input  i2cm_cfg_t cfg,
    output i2cm_out_t result
);

    phase_t                phase_reg, phase_next;
    stage_t                stage_reg, stage_next;
    logic [7:0]            tick_reg, tick_next;
    logic [3:0]            bitc_reg, bitc_next;
    logic [7:0]            shb_reg, shb_next;
    logic [COUNT_BITS-1:0] left_reg, left_next;
    logic [7:0]            dev_reg, dev_next;
    logic [7:0]            regv_reg, regv_next;
    logic [1:0]            kind_reg, kind_next;
    logic [7:0]            awc_reg, awc_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  err_reg, err_next;

    phase_t                ent;
    logic                  do_ent;
    logic                  ack_inc;
    logic                  taken;
    logic                  rvalid;
    logic [7:0]            rbyte;
    logic                  done;
    logic                  stat;
    logic [COUNT_BITS-1:0] cnt;

    assign cnt = item.byte_count[COUNT_BITS-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        stage_next = stage_reg;
        tick_next  = tick_reg;
        bitc_next  = bitc_reg;
        shb_next   = shb_reg;
        left_next  = left_reg;
        dev_next   = dev_reg;
        regv_next  = regv_reg;
        kind_next  = kind_reg;
        awc_next   = awc_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        err_next   = err_reg;
        ent        = PH_IDLE;
        do_ent     = 1'b0;
        ack_inc    = 1'b0;
        taken      = 1'b0;
        rvalid     = 1'b0;
        rbyte      = 8'd0;
        done       = 1'b0;
        stat       = 1'b0;

        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (item.cmd != CMD_TICK)
                    begin
                        kind_next  = item.cmd;
                        stage_next = (item.cmd == CMD_PROBE) ? STG_PROBE : STG_ADDR_W;
                        dev_next   = (item.cmd == CMD_PROBE) ? item.dev_addr
                                                             : (item.dev_addr & DEV_WR_MASK);
                        regv_next  = item.reg_addr;
                        left_next  = cnt;
                        // a zero-length read still fetches one byte
                        if (item.cmd == CMD_READ && cnt == '0)
                            left_next = COUNT_BITS'(1);
                        err_next   = 1'b0;
                        ent        = PH_ST_SDA_H;
                        do_ent     = 1'b1;
                    end
                end
                PH_AK_WAIT:
                begin
                    if (!item.sda_in)
                    begin
                        ent    = PH_AK_SCL_L;
                        do_ent = 1'b1;
                    end
                    else if (awc_reg >= cfg.ack_timeout)
                    begin
                        err_next = 1'b1;
                        ent      = PH_SP_SCL_L;
                        do_ent   = 1'b1;
                    end
                    else
                        awc_next = awc_reg + 8'd1;
                end
                default:
                begin
                    tick_next = tick_reg + 8'd1;
                    if (tick_next >= cfg.phase_ticks)
                    begin
                        do_ent = 1'b1;
                        case (phase_reg)
                            PH_ST_SDA_H: ent = PH_ST_SCL_H;
                            PH_ST_SCL_H: ent = PH_ST_SDA_L;
                            PH_ST_SDA_L: ent = PH_ST_SCL_L;
                            PH_ST_SCL_L:
                            begin
                                shb_next  = (stage_reg == STG_ADDR_R) ? (dev_reg | DEV_RD_BIT)
                                                                      : dev_reg;
                                bitc_next = 4'd0;
                                ent       = PH_TX_DATA;
                            end
                            PH_TX_DATA:  ent = PH_TX_SCL_H;
                            PH_TX_SCL_H: ent = PH_TX_SCL_L;
                            PH_TX_SCL_L:
                            begin
                                shb_next  = {shb_reg[6:0], 1'b0};
                                bitc_next = bitc_reg + 4'd1;
                                ent       = (bitc_next < 4'd8) ? PH_TX_DATA : PH_AK_SDA_H;
                            end
                            PH_AK_SDA_H: ent = PH_AK_SCL_H;
                            PH_AK_SCL_H:
                            begin
                                // first acknowledge sample taken on entry to the wait
                                if (!item.sda_in)
                                    ent = PH_AK_SCL_L;
                                else if (cfg.ack_timeout == 8'd0)
                                begin
                                    err_next = 1'b1;
                                    ent      = PH_SP_SCL_L;
                                end
                                else
                                begin
                                    ent     = PH_AK_WAIT;
                                    ack_inc = 1'b1;
                                end
                            end
                            PH_AK_SCL_L:
                            begin
                                case (stage_reg)
                                    STG_ADDR_W:
                                    begin
                                        stage_next = STG_REG;
                                        shb_next   = regv_reg;
                                        bitc_next  = 4'd0;
                                        ent        = PH_TX_DATA;
                                    end
                                    STG_REG:
                                    begin
                                        if (kind_reg == CMD_READ)
                                        begin
                                            stage_next = STG_ADDR_R;
                                            ent        = PH_ST_SDA_H;
                                        end
                                        else if (left_reg == '0)
                                        begin
                                            err_next = 1'b0;
                                            ent      = PH_SP_SCL_L;
                                        end
                                        else
                                        begin
                                            stage_next = STG_DATA;
                                            taken      = 1'b1;
                                            left_next  = left_reg - COUNT_BITS'(1);
                                            shb_next   = item.write_byte;
                                            bitc_next  = 4'd0;
                                            ent        = PH_TX_DATA;
                                        end
                                    end
                                    STG_ADDR_R:
                                    begin
                                        stage_next = STG_DATA;
                                        bitc_next  = 4'd0;
                                        shb_next   = 8'd0;
                                        ent        = PH_RX_SCL_H;
                                    end
                                    STG_DATA:
                                    begin
                                        if (left_reg == '0)
                                        begin
                                            err_next = 1'b0;
                                            ent      = PH_SP_SCL_L;
                                        end
                                        else
                                        begin
                                            taken     = 1'b1;
                                            left_next = left_reg - COUNT_BITS'(1);
                                            shb_next  = item.write_byte;
                                            bitc_next = 4'd0;
                                            ent       = PH_TX_DATA;
                                        end
                                    end
                                    default:
                                    begin
                                        err_next = 1'b0;
                                        ent      = PH_SP_SCL_L;
                                    end
                                endcase
                            end
                            PH_RX_SCL_H:
                            begin
                                shb_next = {shb_reg[6:0], item.sda_in};
                                ent      = PH_RX_SCL_L;
                            end
                            PH_RX_SCL_L:
                            begin
                                bitc_next = bitc_reg + 4'd1;
                                if (bitc_next < 4'd8)
                                    ent = PH_RX_SCL_H;
                                else
                                begin
                                    rvalid = 1'b1;
                                    rbyte  = shb_reg;
                                    if (left_reg != '0)
                                        left_next = left_reg - COUNT_BITS'(1);
                                    ent = PH_MA_SCL_L;
                                end
                            end
                            PH_MA_SCL_L: ent = PH_MA_SDA;
                            PH_MA_SDA:   ent = PH_MA_SCL_H;
                            PH_MA_SCL_H: ent = PH_MA_SCL_L2;
                            PH_MA_SCL_L2:
                            begin
                                if (left_reg != '0)
                                begin
                                    bitc_next = 4'd0;
                                    shb_next  = 8'd0;
                                    ent       = PH_RX_SCL_H;
                                end
                                else
                                begin
                                    err_next = 1'b0;
                                    ent      = PH_SP_SCL_L;
                                end
                            end
                            PH_SP_SCL_L: ent = PH_SP_SDA_L;
                            PH_SP_SDA_L: ent = PH_SP_SCL_H;
                            PH_SP_SCL_H: ent = PH_SP_SDA_H;
                            PH_SP_SDA_H:
                            begin
                                do_ent     = 1'b0;
                                phase_next = PH_IDLE;
                                tick_next  = 8'd0;
                                done       = 1'b1;
                                stat       = err_reg;
                            end
                            default:
                            begin
                                do_ent     = 1'b0;
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            endcase

            // line levels driven on entry to the new phase
            if (do_ent)
            begin
                phase_next = ent;
                tick_next  = 8'd0;
                if (ent inside {PH_ST_SDA_H, PH_AK_SDA_H, PH_SP_SDA_H, PH_RX_SCL_H})
                    sda_next = 1'b1;
                if (ent inside {PH_ST_SCL_H, PH_TX_SCL_H, PH_AK_SCL_H, PH_MA_SCL_H,
                                PH_SP_SCL_H, PH_RX_SCL_H})
                    scl_next = 1'b1;
                if (ent inside {PH_ST_SDA_L, PH_SP_SDA_L})
                    sda_next = 1'b0;
                if (ent inside {PH_ST_SCL_L, PH_TX_SCL_L, PH_AK_SCL_L, PH_RX_SCL_L,
                                PH_MA_SCL_L, PH_MA_SCL_L2, PH_SP_SCL_L})
                    scl_next = 1'b0;
                if (ent == PH_TX_DATA)
                    sda_next = shb_next[7];
                if (ent == PH_AK_WAIT)
                    awc_next = 8'd0;
                if (ent == PH_MA_SDA)
                    sda_next = (left_next == '0);
            end
            if (ack_inc)
                awc_next = 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            stage_reg <= STG_ADDR_W;
            tick_reg  <= 8'd0;
            bitc_reg  <= 4'd0;
            shb_reg   <= 8'd0;
            left_reg  <= '0;
            dev_reg   <= 8'd0;
            regv_reg  <= 8'd0;
            kind_reg  <= CMD_TICK;
            awc_reg   <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            tick_reg  <= tick_next;
            bitc_reg  <= bitc_next;
            shb_reg   <= shb_next;
            left_reg  <= left_next;
            dev_reg   <= dev_next;
            regv_reg  <= regv_next;
            kind_reg  <= kind_next;
            awc_reg   <= awc_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        result.scl_release = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.byte_taken  = taken;
        result.read_byte   = rbyte;
        result.read_valid  = rvalid;
        result.done_res    = done;
        result.status      = stat;
    end

    `CHK_HOLDS(a_bitc_range, bitc_reg <= 4'd8, "bit counter past eight")
    `CHK_IMPLIES(a_idle_tick, phase_reg == PH_IDLE, tick_reg == 8'd0,
        "tick counter running while idle")
    `CHK_NEXT(a_ack_low, step && phase_reg == PH_AK_WAIT && !item.sda_in,
        phase_reg == PH_AK_SCL_L, "low sda in acknowledge wait not taken as ack")

endmodule

@@ hdl/i2c_master_register_access_top.sv @@
// top level of the i2c master register access sequencer
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel  handshake             payload
//  req      req_valid/req_ready   i2cm_in_t: one bus tick, command, pin sample
//  rsp      rsp_valid/rsp_ready   i2cm_out_t: pin levels and status after the tick
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data: phase_ticks, ack_timeout
//
//  one tick per clock sustained while rsp_ready stays high; a tick lands in the
//  input register, the phase sequencer works out the outcome combinationally
//  and the result register captures it at the edge that updates the sequencer state
//  an empty input register takes new ticks while a result still waits on rsp_ready
//  reset (rst_n low, asynchronous) leaves the bus released and the sequencer idle
//  cfg_ready is always high; the user must write registers only between transactions, the block does not enforce it

module i2c_master_register_access_top
    import i2cm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  i2cm_in_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output i2cm_out_t            rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    // input register stage
    logic      s1_valid_reg, s1_valid_next;
    i2cm_in_t  s1_item_reg;
    logic      s1_adv;

    // result register stage
    logic      rsp_valid_reg, rsp_valid_next;
    i2cm_out_t rsp_reg;

    i2cm_cfg_t cfg;
    i2cm_out_t step_res;

    // the tick moves on once the result register is free or being emptied
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_valid && req_ready)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (s1_adv)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            s1_item_reg <= req;
        if (s1_adv)
            rsp_reg <= step_res;
    end

    i2cm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cm_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_adv),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (step_res)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `CHK_IMPLIES(a_done_idle, rsp_valid && rsp.done_res, !rsp.busy_res,
        "done reported while still busy")
    `CHK_IMPLIES(a_status_done, rsp_valid && rsp.status, rsp.done_res,
        "error status without done")
    `CHK_NEXT(a_stall_keeps, s1_valid_reg && !s1_adv, s1_valid_reg,
        "stalled tick dropped from input register")

endmodule

@@ tb/sv/tb_i2c_master_register_access_top.sv @@
// self-checking testbench: drives bus ticks through the i2c master sequencer and checks pin levels and result flags
`timescale 1ns / 1ps

module tb_i2c_master_register_access_top;
    import i2cm_pkg::*;

    localparam int unsigned IDLE_PCT     = 23;    // chance of an idle cycle on either side
    localparam int unsigned HOLD_CYCLES  = 300;   // long result hold-off to back up the block
    localparam int unsigned STALL_LIMIT  = 4000;  // cycles without any transaction
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned TAIL_CYCLES  = 8;     // settle time after the last result
    localparam int unsigned PHASE_BUDGET = 40;    // minimum ticks per random phase

    // tracks the sequencer tick by tick and holds the pin levels still to come back
    class bus_pin_tracker;
        logic [7:0]  phase_ticks;
        logic [7:0]  ack_timeout;
        phase_t      phase;
        stage_t      stage;
        logic [7:0]  tick_cnt;
        logic [3:0]  bit_cnt;
        logic [7:0]  shreg;
        logic [15:0] bytes_left;
        logic [7:0]  dev_sv;
        logic [7:0]  reg_sv;
        logic [1:0]  cmd_kind;
        logic [7:0]  ack_cnt;
        logic        scl_lvl;
        logic        sda_lvl;
        logic        nack_flag;
        logic [7:0]  wbyte;
        i2cm_out_t   res;
        i2cm_out_t   pending_pins[$];
        int unsigned faults;

        function new();
            phase_ticks = PHASE_TICKS_RST;
            ack_timeout = ACK_TIMEOUT_RST;
            phase       = PH_IDLE;
            stage       = STG_ADDR_W;
            tick_cnt    = '0;
            bit_cnt     = '0;
            shreg       = '0;
            bytes_left  = '0;
            dev_sv      = '0;
            reg_sv      = '0;
            cmd_kind    = CMD_TICK;
            ack_cnt     = '0;
            scl_lvl     = 1'b1;
            sda_lvl     = 1'b1;
            nack_flag   = 1'b0;
            wbyte       = '0;
            faults      = 0;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_PHASE_TICKS)
                phase_ticks = val;
            else if (idx == CFG_ACK_TIMEOUT)
                ack_timeout = val;
        endfunction

        function void enter_phase(phase_t ph);
            phase    = ph;
            tick_cnt = '0;
            case (ph)
                PH_ST_SDA_H, PH_AK_SDA_H, PH_SP_SDA_H: sda_lvl = 1'b1;
                PH_ST_SCL_H, PH_TX_SCL_H, PH_AK_SCL_H, PH_MA_SCL_H, PH_SP_SCL_H: scl_lvl = 1'b1;
                PH_ST_SDA_L, PH_SP_SDA_L: sda_lvl = 1'b0;
                PH_ST_SCL_L, PH_TX_SCL_L, PH_AK_SCL_L, PH_RX_SCL_L,
                PH_MA_SCL_L, PH_MA_SCL_L2, PH_SP_SCL_L: scl_lvl = 1'b0;
                PH_TX_DATA:  sda_lvl = shreg[7];
                PH_AK_WAIT:  ack_cnt = '0;
                PH_RX_SCL_H:
                begin
                    sda_lvl = 1'b1;
                    scl_lvl = 1'b1;
                end
                PH_MA_SDA:   sda_lvl = (bytes_left == 16'd0);
                default: ;
            endcase
        endfunction

        function void send_byte(logic [7:0] v);
            shreg   = v;
            bit_cnt = '0;
            enter_phase(PH_TX_DATA);
        endfunction

        function void send_data();
            res.byte_taken = 1'b1;
            bytes_left     = bytes_left - 16'd1;
            send_byte(wbyte);
        endfunction

        function void begin_stop(logic nack);
            nack_flag = nack;
            enter_phase(PH_SP_SCL_L);
        endfunction

        function void ack_sample(logic sda);
            if (!sda)
                enter_phase(PH_AK_SCL_L);
            else if (ack_cnt >= ack_timeout)
                begin_stop(1'b1);
            else
                ack_cnt++;
        endfunction

        function void after_ack();
            case (stage)
                STG_ADDR_W:
                begin
                    stage = STG_REG;
                    send_byte(reg_sv);
                end
                STG_REG:
                begin
                    if (cmd_kind == CMD_READ)
                    begin
                        stage = STG_ADDR_R;
                        enter_phase(PH_ST_SDA_H);
                    end
                    else if (bytes_left == 16'd0)
                        begin_stop(1'b0);
                    else
                    begin
                        stage = STG_DATA;
                        send_data();
                    end
                end
                STG_ADDR_R:
                begin
                    stage   = STG_DATA;
                    bit_cnt = '0;
                    shreg   = '0;
                    enter_phase(PH_RX_SCL_H);
                end
                STG_DATA:
                begin
                    if (bytes_left == 16'd0)
                        begin_stop(1'b0);
                    else
                        send_data();
                end
                default: begin_stop(1'b0);
            endcase
        endfunction

        function void complete(logic sda);
            case (phase)
                PH_ST_SDA_H: enter_phase(PH_ST_SCL_H);
                PH_ST_SCL_H: enter_phase(PH_ST_SDA_L);
                PH_ST_SDA_L: enter_phase(PH_ST_SCL_L);
                PH_ST_SCL_L: send_byte(stage == STG_ADDR_R ? (dev_sv | DEV_RD_BIT) : dev_sv);
                PH_TX_DATA:  enter_phase(PH_TX_SCL_H);
                PH_TX_SCL_H: enter_phase(PH_TX_SCL_L);
                PH_TX_SCL_L:
                begin
                    shreg = shreg << 1;
                    bit_cnt++;
                    if (bit_cnt < 4'd8)
                        enter_phase(PH_TX_DATA);
                    else
                        enter_phase(PH_AK_SDA_H);
                end
                PH_AK_SDA_H: enter_phase(PH_AK_SCL_H);
                PH_AK_SCL_H:
                begin
                    enter_phase(PH_AK_WAIT);
                    ack_sample(sda);
                end
                PH_AK_SCL_L: after_ack();
                PH_RX_SCL_H:
                begin
                    shreg = {shreg[6:0], sda};
                    enter_phase(PH_RX_SCL_L);
                end
                PH_RX_SCL_L:
                begin
                    bit_cnt++;
                    if (bit_cnt < 4'd8)
                        enter_phase(PH_RX_SCL_H);
                    else
                    begin
                        res.read_valid = 1'b1;
                        res.read_byte  = shreg;
                        if (bytes_left != 16'd0)
                            bytes_left = bytes_left - 16'd1;
                        enter_phase(PH_MA_SCL_L);
                    end
                end
                PH_MA_SCL_L: enter_phase(PH_MA_SDA);
                PH_MA_SDA:   enter_phase(PH_MA_SCL_H);
                PH_MA_SCL_H: enter_phase(PH_MA_SCL_L2);
                PH_MA_SCL_L2:
                begin
                    if (bytes_left != 16'd0)
                    begin
                        bit_cnt = '0;
                        shreg   = '0;
                        enter_phase(PH_RX_SCL_H);
                    end
                    else
                        begin_stop(1'b0);
                end
                PH_SP_SCL_L: enter_phase(PH_SP_SDA_L);
                PH_SP_SDA_L: enter_phase(PH_SP_SCL_H);
                PH_SP_SCL_H: enter_phase(PH_SP_SDA_H);
                PH_SP_SDA_H:
                begin
                    phase      = PH_IDLE;
                    tick_cnt   = '0;
                    res.done_res = 1'b1;
                    res.status   = nack_flag;
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        // one bus tick: pin levels and flags after this tick
        function i2cm_out_t advance_bus(i2cm_in_t it);
            logic [7:0] p;
            p     = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
            wbyte = it.write_byte;
            res   = '0;
            if (phase == PH_IDLE)
            begin
                if (it.cmd != CMD_TICK)
                begin
                    cmd_kind   = it.cmd;
                    stage      = (it.cmd == CMD_PROBE) ? STG_PROBE : STG_ADDR_W;
                    dev_sv     = (it.cmd == CMD_PROBE) ? it.dev_addr : (it.dev_addr & DEV_WR_MASK);
                    reg_sv     = it.reg_addr;
                    bytes_left = it.byte_count;  // full 16-bit count at the default width
                    if (it.cmd == CMD_READ && bytes_left == 16'd0)
                        bytes_left = 16'd1;
                    nack_flag  = 1'b0;
                    enter_phase(PH_ST_SDA_H);
                end
            end
            else if (phase == PH_AK_WAIT)
                ack_sample(it.sda_in);
            else
            begin
                tick_cnt++;
                if (tick_cnt >= p)
                    complete(it.sda_in);
            end
            res.scl_release = scl_lvl;
            res.sda_release = sda_lvl;
            res.busy_res    = (phase != PH_IDLE);
            return res;
        endfunction

        function void take_tick(i2cm_in_t it);
            pending_pins.push_back(advance_bus(it));
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                faults++;
            end
        endfunction

        function void match_pins(i2cm_out_t got);
            i2cm_out_t want;
            if (pending_pins.size() == 0)
            begin
                $error("result with nothing outstanding: %0h", got);
                faults++;
                return;
            end
            want = pending_pins.pop_front();
            check_field("scl_release", 8'(want.scl_release), 8'(got.scl_release));
            check_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
            check_field("busy_res",    8'(want.busy_res),    8'(got.busy_res));
            check_field("byte_taken",  8'(want.byte_taken),  8'(got.byte_taken));
            check_field("read_byte",   want.read_byte,       got.read_byte);
            check_field("read_valid",  8'(want.read_valid),  8'(got.read_valid));
            check_field("done_res",    8'(want.done_res),    8'(got.done_res));
            check_field("status",      8'(want.status),      8'(got.status));
        endfunction
    endclass

    // clock, reset and the three channels; every input starts at a known level
    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    i2cm_in_t             req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    i2cm_out_t            rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PHASE_TICKS;
    logic [7:0]           cfg_data  = 8'd0;

    bus_pin_tracker chk = new();

    // knobs shared between the stimulus and the result sink
    bit          sender_gaps   = 1'b1;
    bit          sink_stalls   = 1'b1;
    bit          sink_hold_req = 1'b0;
    int unsigned ticks_sent    = 0;

    i2c_master_register_access_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one tick with random content; the device pulls sda low in the acknowledge
    // window with the given percentage, elsewhere sda is random (read data bits)
    // cmd is random too, so commands arrive while a transfer is running
    function automatic i2cm_in_t bus_tick(int unsigned ack_pct);
        i2cm_in_t it;
        it.cmd        = 2'($urandom_range(CMD_TICK, CMD_PROBE));
        it.dev_addr   = 8'($urandom);
        it.reg_addr   = 8'($urandom);
        it.byte_count = 16'($urandom);
        it.write_byte = 8'($urandom);
        if (chk.phase inside {PH_AK_SCL_H, PH_AK_WAIT})
            it.sda_in = ($urandom_range(99) >= ack_pct);
        else
            it.sda_in = 1'($urandom_range(1));
        return it;
    endfunction

    // offers one tick and holds it until the request transaction completes;
    // the tracker learns of it at the accepting edge
    task automatic push_tick(i2cm_in_t it);
        if (sender_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        chk.take_tick(it);
        ticks_sent++;
    endtask

    task automatic idle_ticks(int unsigned n);
        i2cm_in_t it;
        repeat (n)
        begin
            it     = bus_tick(100);
            it.cmd = CMD_TICK;
            push_tick(it);
        end
    endtask

    // a command tick, then ticks until the tracker sees the bus idle again
    task automatic run_transfer(logic [1:0] kind, logic [7:0] dev, logic [7:0] rg,
                                logic [15:0] cnt, int unsigned ack_pct);
        i2cm_in_t it;
        it            = bus_tick(ack_pct);
        it.cmd        = kind;
        it.dev_addr   = dev;
        it.reg_addr   = rg;
        it.byte_count = cnt;
        push_tick(it);
        while (chk.phase != PH_IDLE)
            push_tick(bus_tick(ack_pct));
    endtask

    // sender stops and waits until every result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (chk.pending_pins.size() != 0);
    endtask

    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        chk.configure(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reconfigure(logic [7:0] pt, logic [7:0] at);
        drain_results();
        write_setting(CFG_PHASE_TICKS, pt);
        write_setting(CFG_ACK_TIMEOUT, at);
    endtask

    // mostly answering devices and short counts; absent devices get any count
    task automatic random_transfer();
        logic [1:0]  kind;
        logic [15:0] cnt;
        int unsigned pick;
        int unsigned ack_pct;
        kind = 2'($urandom_range(CMD_READ, CMD_PROBE));
        pick = $urandom_range(99);
        if (pick < 60)
            ack_pct = 100;
        else if (pick < 85)
            ack_pct = 90;
        else if (pick < 95)
            ack_pct = 50;
        else
            ack_pct = 0;
        if (ack_pct == 0)
            cnt = 16'($urandom);
        else if ($urandom_range(7) == 0)
            cnt = 16'($urandom_range(4, 8));
        else
            cnt = 16'($urandom_range(0, 3));
        run_transfer(kind, 8'($urandom), 8'($urandom), cnt, ack_pct);
    endtask

    task automatic random_phase(int unsigned budget);
        int unsigned start;
        start = ticks_sent;
        while (ticks_sent - start < budget)
        begin
            idle_ticks($urandom_range(0, 3));
            random_transfer();
            if ($urandom_range(15) == 0)
                drain_results();
        end
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                chk.match_pins(rsp);
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES - 1;
                rsp_ready     <= 1'b0;
            end
            else
                rsp_ready <= !(sink_stalls && $urandom_range(99) < IDLE_PCT);
        end
    end

    // ends the run when no transaction of any channel completes for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_i2c_master_register_access_top: errors");
        $finish;
    end

    initial
    begin : stimulus
        i2cm_in_t it;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks with every field at its extremes
        it     = '1;
        it.cmd = CMD_TICK;
        push_tick(it);
        it     = '0;
        push_tick(it);

        // reset settings: a probe at six ticks per phase
        run_transfer(CMD_PROBE, 8'h00, 8'h00, 16'd0, 100);

        // zero ack timeout: the first high sample is a nack; empty register write
        reconfigure(8'd1, 8'd0);
        run_transfer(CMD_PROBE, 8'hFF, 8'h5A, 16'd0, 50);
        run_transfer(CMD_WRITE, 8'hFF, 8'hFF, 16'd0, 100);
        run_transfer(CMD_WRITE, 8'hA0, 8'h10, 16'd2, 100);
        run_transfer(CMD_WRITE, 8'hA1, 8'h7F, 16'hFFFF, 0);

        // zero phase ticks behaves as one tick per phase; empty read fetches one byte
        reconfigure(8'd0, 8'd3);
        run_transfer(CMD_READ,  8'h51, 8'h00, 16'd0, 100);
        run_transfer(CMD_READ,  8'h3C, 8'h80, 16'd3, 100);
        run_transfer(CMD_READ,  8'hC3, 8'h01, 16'hFFFF, 0);
        run_transfer(CMD_WRITE, 8'h12, 8'hEE, 16'd1, 90);

        // longest acknowledge wait, device absent
        reconfigure(8'd1, 8'd255);
        run_transfer(CMD_PROBE, 8'h3B, 8'h00, 16'd0, 0);

        // random phases at one tick per phase and an ack timeout of two
        reconfigure(8'd1, 8'd2);
        random_phase(PHASE_BUDGET);

        // long stretch with neither side idling
        reconfigure(8'd2, 8'd255);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        random_phase(PHASE_BUDGET);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;

        // result side holds off while ticks keep coming, so the block backs up
        reconfigure(8'd1, 8'd0);
        sink_hold_req = 1'b1;
        random_phase(PHASE_BUDGET);

        reconfigure(8'd1, 8'($urandom));
        random_phase(PHASE_BUDGET);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (chk.faults == 0)
            $display("tb_i2c_master_register_access_top: clean");
        else
            $display("tb_i2c_master_register_access_top: errors");
        $finish;
    end

endmodule

@@ i2c_master_register_access_top.f @@
+incdir+hdl
hdl/i2cm_pkg.sv
hdl/i2cm_cfg.sv
hdl/i2cm_seq.sv
hdl/i2c_master_register_access_top.sv
tb/sv/tb_i2c_master_register_access_top.sv
